@@ hw/rtl/scfs_pkg.sv @@
// Shared constants and descriptor field helpers for the sprite clip frame sequencer.
// Depends on nothing; the top level takes everything here by scoped names.
`default_nettype none

package scfs_pkg;

	// Sizing of the block.
	localparam int NUM_CLIPS    = 4;
	localparam int ELAPSED_BITS = 32;
	localparam int NUM_DESC     = 4;
	localparam int CLIP_BITS    = 2;
	localparam int FRAME_BITS   = 8;
	localparam int PERIOD_BITS  = 24;
	localparam int DESC_BITS    = 37;
	localparam int DELTA_BITS   = 16;

	// Microseconds per millisecond, as a narrow constant multiplier.
	localparam logic [9:0] US_PER_MS = 10'd1000;
	localparam int PROD_BITS = DELTA_BITS + 10;

	// The accumulate is one bit wider than both operands so that a carry shows.
	localparam int SUM_BITS = ((ELAPSED_BITS > PROD_BITS) ? ELAPSED_BITS : PROD_BITS) + 1;

	// The divider dividend holds either the elapsed time or a frame position,
	// which may exceed the elapsed range by a few hundred.
	localparam int QUO_BITS = ELAPSED_BITS + 1;
	localparam int CNT_BITS = $clog2(QUO_BITS);

	// Descriptor layout.
	localparam int FRAMES_LSB  = 0;
	localparam int PERIOD_LSB  = 8;
	localparam int LOOP_BIT    = 32;
	localparam int HASNEXT_BIT = 33;
	localparam int NEXT_LSB    = 34;
	localparam int PRESENT_BIT = 36;

	// Input command codes.
	localparam logic CMD_TICK    = 1'b0;
	localparam logic CMD_REQUEST = 1'b1;

	typedef logic [DESC_BITS-1:0] desc_t;

	function automatic logic [FRAME_BITS-1:0] desc_frames(input desc_t d);
		return d[FRAMES_LSB +: FRAME_BITS];
	endfunction

	function automatic logic [PERIOD_BITS-1:0] desc_period(input desc_t d);
		return d[PERIOD_LSB +: PERIOD_BITS];
	endfunction

	function automatic logic [CLIP_BITS-1:0] desc_next(input desc_t d);
		return d[NEXT_LSB +: CLIP_BITS];
	endfunction

	// A clip counts only if its present bit is set and the index is implemented.
	function automatic logic clip_present(input desc_t d, input logic [CLIP_BITS-1:0] c);
		return d[PRESENT_BIT] && (32'(c) < 32'(NUM_CLIPS));
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sprite_clip_frame_sequencer_top.sv @@
// Top level of the sprite clip frame sequencer: descriptor registers, state,
// sequencer and one shared restoring divider. Depends on scfs_pkg.
`default_nettype none

// Channel    | Direction | Handshake            | Payload
// -----------+-----------+----------------------+--------------------------------------
// input      | in        | in_valid / in_ready  | cmd, clip_sel, delta_ms
// result     | out       | out_valid / out_ready| active_clip, frame_number, frame_valid
// config     | in        | cfg_we (no wait)     | cfg_index, cfg_data
//
// One transaction is worked on at a time; in_ready is high only while the sequencer idles.
// A request goes straight to the done step; a tick first checks its clip. A tick that
// advances frames then runs the period division and a post step, and a looping clip a second
// division for the wrap and a second post step; both divisions use the one-bit-per-cycle
// shared divider.
// The finished result sits in an output register; a new transaction may be accepted while it
// waits, and the sequencer stalls at its last step only if the previous result is still held.
// Reset clears descriptors, clip state and all control; no clearing pass is needed.

module sprite_clip_frame_sequencer_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  cmd,
	input  logic [scfs_pkg::CLIP_BITS-1:0]        clip_sel,
	input  logic [scfs_pkg::DELTA_BITS-1:0]       delta_ms,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [scfs_pkg::CLIP_BITS-1:0]        active_clip,
	output logic [scfs_pkg::FRAME_BITS-1:0]       frame_number,
	output logic                                  frame_valid,
	input  logic                                  cfg_we,
	input  logic [scfs_pkg::CLIP_BITS-1:0]        cfg_index,
	input  logic [scfs_pkg::DESC_BITS-1:0]        cfg_data
);

	localparam int EB = scfs_pkg::ELAPSED_BITS;
	localparam int QB = scfs_pkg::QUO_BITS;
	localparam int PB = scfs_pkg::PERIOD_BITS;
	localparam int FB = scfs_pkg::FRAME_BITS;
	localparam int SB = scfs_pkg::SUM_BITS;

	// Sequencer states, one-hot.
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CHECK = 6'b000010,
		ST_DIV   = 6'b000100,
		ST_POST1 = 6'b001000,
		ST_POST2 = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t state_q;

	// Descriptor registers.
	scfs_pkg::desc_t desc_q [scfs_pkg::NUM_DESC];

	// Architectural clip state.
	logic [scfs_pkg::CLIP_BITS-1:0] cur_q;
	logic [FB-1:0]                  idx_q;
	logic [EB-1:0]                  elapsed_q;

	// Fields of the current clip latched in the check step of every tick.
	logic [FB-1:0]                  frames_q;
	logic                           loop_q;
	logic                           has_next_q;
	logic [scfs_pkg::CLIP_BITS-1:0] next_q;

	// Shared divider: dividend shifts out of quo_q as quotient bits shift in.
	logic [QB-1:0]                  quo_q;
	logic [PB-1:0]                  rem_q;
	logic [PB-1:0]                  div_q;
	logic [scfs_pkg::CNT_BITS-1:0]  cnt_q;
	logic                           phase_q;

	// Output register.
	logic                           out_valid_q;
	logic [scfs_pkg::CLIP_BITS-1:0] active_clip_q;
	logic [FB-1:0]                  frame_number_q;
	logic                           frame_valid_q;

	// The descriptor bank has a single read port whose address the state picks.
	logic [scfs_pkg::CLIP_BITS-1:0] rd_addr;
	scfs_pkg::desc_t                desc_rd;
	logic                           rd_present;
	logic [FB-1:0]                  rd_frames;
	logic [PB-1:0]                  rd_period;

	always_comb begin
		unique case (state_q)
			ST_IDLE:  rd_addr = clip_sel;
			ST_POST1: rd_addr = next_q;
			default:  rd_addr = cur_q;
		endcase
	end

	assign desc_rd    = desc_q[rd_addr];
	assign rd_present = scfs_pkg::clip_present(desc_rd, rd_addr);
	assign rd_frames  = scfs_pkg::desc_frames(desc_rd);
	assign rd_period  = scfs_pkg::desc_period(desc_rd);

	// Tick accumulate with saturation at the top of the elapsed range.
	logic [SB-1:0] prod;
	logic [SB-1:0] sum;
	logic [EB-1:0] sum_sat;

	assign prod    = SB'(delta_ms) * SB'(scfs_pkg::US_PER_MS);
	assign sum     = SB'(elapsed_q) + prod;
	assign sum_sat = (|sum[SB-1:EB]) ? {EB{1'b1}} : sum[EB-1:0];

	// A tick advances only on a present clip with a nonzero count and period once a
	// whole period has gone by.
	logic go_div;
	assign go_div = rd_present && (rd_frames != '0) && (rd_period != '0) &&
		(elapsed_q >= EB'(rd_period));

	// One restoring division step.
	logic [PB:0]   trial;
	logic [PB:0]   diff;
	logic          ge;
	logic [PB-1:0] rem_nxt;

	assign trial   = {rem_q, quo_q[QB-1]};
	assign ge      = trial >= {1'b0, div_q};
	assign diff    = trial - {1'b0, div_q};
	assign rem_nxt = ge ? diff[PB-1:0] : trial[PB-1:0];

	logic div_last;
	assign div_last = (cnt_q == scfs_pkg::CNT_BITS'(QB - 1));

	// Frame arithmetic after the period division. n is the number of whole periods.
	logic [EB-1:0] n_periods;
	logic          at_last;
	logic [FB-1:0] first_idx;
	logic [QB-1:0] wrap_pos;
	logic [FB:0]   left_k;
	logic          n_lt_k;

	assign n_periods = quo_q[EB-1:0];
	assign at_last   = ({1'b0, idx_q} + (FB+1)'(1)) >= {1'b0, frames_q};
	assign first_idx = at_last ? '0 : (idx_q + FB'(1));
	assign wrap_pos  = QB'(n_periods) + QB'(first_idx) - QB'(1);
	assign left_k    = at_last ? (FB+1)'(1) : ({1'b0, frames_q} - {1'b0, idx_q});
	assign n_lt_k    = n_periods < EB'(left_k);

	logic can_follow;
	assign can_follow = has_next_q && (next_q != cur_q) && rd_present;

	// The result reflects the state after the update and the current descriptor.
	logic res_valid;
	assign res_valid = rd_present && (idx_q < rd_frames);

	logic out_free;
	assign out_free = !out_valid_q || out_ready;

	assign in_ready     = (state_q == ST_IDLE);
	assign out_valid    = out_valid_q;
	assign active_clip  = active_clip_q;
	assign frame_number = frame_number_q;
	assign frame_valid  = frame_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			for (int i = 0; i < scfs_pkg::NUM_DESC; i++) begin
				desc_q[i] <= '0;
			end
			cur_q          <= '0;
			idx_q          <= '0;
			elapsed_q      <= '0;
			frames_q       <= '0;
			loop_q         <= 1'b0;
			has_next_q     <= 1'b0;
			next_q         <= '0;
			quo_q          <= '0;
			rem_q          <= '0;
			div_q          <= '0;
			cnt_q          <= '0;
			phase_q        <= 1'b0;
			out_valid_q    <= 1'b0;
			active_clip_q  <= '0;
			frame_number_q <= '0;
			frame_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				desc_q[cfg_index] <= cfg_data;
			end

			// In the last step the result register is handled by the sequencer itself.
			if (out_valid_q && out_ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (cmd == scfs_pkg::CMD_REQUEST) begin
							// Switch only to a different clip that is present.
							if ((clip_sel != cur_q) && rd_present) begin
								cur_q     <= clip_sel;
								idx_q     <= '0;
								elapsed_q <= '0;
							end
							state_q <= ST_DONE;
						end else begin
							elapsed_q <= sum_sat;
							state_q   <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					frames_q   <= rd_frames;
					loop_q     <= desc_rd[scfs_pkg::LOOP_BIT];
					has_next_q <= desc_rd[scfs_pkg::HASNEXT_BIT];
					next_q     <= scfs_pkg::desc_next(desc_rd);
					quo_q      <= {1'b0, elapsed_q};
					rem_q      <= '0;
					div_q      <= rd_period;
					cnt_q      <= '0;
					phase_q    <= 1'b0;
					state_q    <= go_div ? ST_DIV : ST_DONE;
				end
				ST_DIV: begin
					quo_q <= {quo_q[QB-2:0], ge};
					rem_q <= rem_nxt;
					cnt_q <= cnt_q + scfs_pkg::CNT_BITS'(1);
					if (div_last) begin
						state_q <= phase_q ? ST_POST2 : ST_POST1;
					end
				end
				ST_POST1: begin
					// The remainder of the period division is the time left over, unless
					// the clip hands over to its follower, which starts from zero.
					if (loop_q) begin
						elapsed_q <= EB'(rem_q);
						quo_q     <= wrap_pos;
						rem_q     <= '0;
						div_q     <= PB'(frames_q);
						cnt_q     <= '0;
						phase_q   <= 1'b1;
						state_q   <= ST_DIV;
					end else begin
						if (n_lt_k) begin
							elapsed_q <= EB'(rem_q);
							idx_q     <= idx_q + n_periods[FB-1:0];
						end else if (can_follow) begin
							cur_q     <= next_q;
							idx_q     <= '0;
							elapsed_q <= '0;
						end else begin
							elapsed_q <= EB'(rem_q);
							idx_q     <= frames_q - FB'(1);
						end
						state_q <= ST_DONE;
					end
				end
				ST_POST2: begin
					// Looping clip: the position modulo the frame count.
					idx_q   <= rem_q[FB-1:0];
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q    <= 1'b1;
						active_clip_q  <= cur_q;
						frame_number_q <= idx_q;
						frame_valid_q  <= res_valid;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ tb/sprite_clip_frame_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the sprite clip frame sequencer: mirrors the descriptor writes, predicts the
// frame report of every accepted transaction and compares it with the result channel.
// Depends on scfs_pkg for widths, descriptor layout and command codes.

module sprite_clip_frame_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic                                  in_ready,
	input  logic                                  cmd,
	input  logic [scfs_pkg::CLIP_BITS-1:0]        clip_sel,
	input  logic [scfs_pkg::DELTA_BITS-1:0]       delta_ms,
	input  logic                                  out_valid,
	input  logic                                  out_ready,
	input  logic [scfs_pkg::CLIP_BITS-1:0]        active_clip,
	input  logic [scfs_pkg::FRAME_BITS-1:0]       frame_number,
	input  logic                                  frame_valid,
	input  logic                                  cfg_we,
	input  logic [scfs_pkg::CLIP_BITS-1:0]        cfg_index,
	input  logic [scfs_pkg::DESC_BITS-1:0]        cfg_data,
	output int                                    fail_count,
	output int                                    pending,
	output int                                    reports_checked
);
	import scfs_pkg::*;

	typedef struct packed {
		logic [CLIP_BITS-1:0]  clip;
		logic [FRAME_BITS-1:0] frame;
		logic                  shown;
	} frame_report_t;

	localparam logic [63:0] ELAPSED_CEIL = (64'd1 << ELAPSED_BITS) - 64'd1;
	localparam int NOISY_LIMIT = 40;

	desc_t                 desc_copy [NUM_DESC];
	logic [CLIP_BITS-1:0]  cur_clip;
	logic [FRAME_BITS-1:0] cur_frame;
	logic [63:0]           elapsed;
	frame_report_t         expected_frames [$];
	frame_report_t         oldest;
	int                    mismatches;
	int                    checked;

	function automatic logic clip_on(input logic [CLIP_BITS-1:0] c);
		return desc_copy[c][PRESENT_BIT] && (int'(c) < NUM_CLIPS);
	endfunction

	// A request restarts a different clip that is present; anything else is ignored.
	task automatic enter_clip(input logic [CLIP_BITS-1:0] c);
		if (c != cur_clip && clip_on(c)) begin
			cur_clip  = c;
			cur_frame = '0;
			elapsed   = '0;
		end
	endtask

	task automatic accumulate_time(input logic [DELTA_BITS-1:0] delta);
		desc_t                 d;
		logic [63:0]           sum;
		logic [63:0]           period;
		logic [63:0]           n;
		logic [63:0]           k;
		logic [63:0]           first;
		logic [FRAME_BITS-1:0] frames;
		d      = desc_copy[cur_clip];
		sum    = elapsed + 64'(delta) * 64'd1000;
		elapsed = (sum > ELAPSED_CEIL) ? ELAPSED_CEIL : sum;
		frames = d[FRAMES_LSB +: FRAME_BITS];
		period = 64'(d[PERIOD_LSB +: PERIOD_BITS]);
		if (!clip_on(cur_clip) || frames == 0 || period == 0 || elapsed < period)
			return;
		n = elapsed / period;
		elapsed = elapsed - n * period;
		if (d[LOOP_BIT]) begin
			first = (64'(cur_frame) + 1 >= 64'(frames)) ? 64'd0 : 64'(cur_frame) + 1;
			cur_frame = FRAME_BITS'((first + n - 1) % 64'(frames));
			return;
		end
		k = (64'(cur_frame) + 1 >= 64'(frames)) ? 64'd1 : 64'(frames) - 64'(cur_frame);
		if (n < k) begin
			cur_frame = cur_frame + FRAME_BITS'(n);
			return;
		end
		cur_frame = frames - 1'b1;
		if (d[HASNEXT_BIT])
			enter_clip(d[NEXT_LSB +: CLIP_BITS]);
	endtask

	function automatic frame_report_t current_report();
		frame_report_t r;
		r.clip  = cur_clip;
		r.frame = cur_frame;
		r.shown = clip_on(cur_clip) && (cur_frame < desc_copy[cur_clip][FRAMES_LSB +: FRAME_BITS]);
		return r;
	endfunction

	task automatic flag_field(input string field, input logic [FRAME_BITS-1:0] want,
			input logic [FRAME_BITS-1:0] got);
		mismatches++;
		if (mismatches <= NOISY_LIMIT)
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (desc_copy[i])
				desc_copy[i] = '0;
			cur_clip   = '0;
			cur_frame  = '0;
			elapsed    = '0;
			expected_frames.delete();
			mismatches = 0;
			checked    = 0;
		end else begin
			if (cfg_we)
				desc_copy[cfg_index] = cfg_data;
			if (in_valid && in_ready) begin
				if (cmd == CMD_REQUEST)
					enter_clip(clip_sel);
				else
					accumulate_time(delta_ms);
				expected_frames.push_back(current_report());
			end
			if (out_valid && out_ready) begin
				checked++;
				if (expected_frames.size() == 0) begin
					mismatches++;
					if (mismatches <= NOISY_LIMIT)
						$display("%0t: unexpected result, expected none, got clip %0d frame %0d valid %0d",
							$time, active_clip, frame_number, frame_valid);
				end else begin
					oldest = expected_frames.pop_front();
					if (oldest.clip !== active_clip)
						flag_field("active_clip", oldest.clip, active_clip);
					if (oldest.frame !== frame_number)
						flag_field("frame_number", oldest.frame, frame_number);
					if (oldest.shown !== frame_valid)
						flag_field("frame_valid", oldest.shown, frame_valid);
				end
			end
		end
		fail_count      <= mismatches;
		pending         <= expected_frames.size();
		reports_checked <= checked;
	end

endmodule

@@ tb/sprite_clip_frame_sequencer_top_tb.sv @@
`timescale 1ns / 100ps
// Stimulus and verdict for the sprite clip frame sequencer: drives requests, ticks and
// descriptor writes, and leaves prediction and comparison to sprite_clip_frame_checker.
// Depends on scfs_pkg, sprite_clip_frame_sequencer_top and sprite_clip_frame_checker.

module sprite_clip_frame_sequencer_top_tb;
	import scfs_pkg::*;

	// Clip numbers double as descriptor register indexes: register i describes clip i.
	localparam logic [CLIP_BITS-1:0] CLIP0 = 2'd0;
	localparam logic [CLIP_BITS-1:0] CLIP1 = 2'd1;
	localparam logic [CLIP_BITS-1:0] CLIP2 = 2'd2;
	localparam logic [CLIP_BITS-1:0] CLIP3 = 2'd3;

	// The slowest transaction is a looping tick, which runs the divider twice; the drain and the final
	// wait leave room for that plus a long stall of the result channel.
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES   = 120;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int RANDOM_PHASES = 8;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  in_valid     = 1'b0;
	logic                  in_ready;
	logic                  cmd          = CMD_TICK;
	logic [CLIP_BITS-1:0]  clip_sel     = '0;
	logic [DELTA_BITS-1:0] delta_ms     = '0;
	logic                  out_valid;
	logic                  out_ready    = 1'b0;
	logic [CLIP_BITS-1:0]  active_clip;
	logic [FRAME_BITS-1:0] frame_number;
	logic                  frame_valid;
	logic                  cfg_we       = 1'b0;
	logic [CLIP_BITS-1:0]  cfg_index    = '0;
	desc_t                 cfg_data     = '0;

	int fail_count;
	int pending;
	int reports_checked;
	int cycle_count   = 0;
	int requests_sent = 0;
	int ticks_sent    = 0;
	int desc_writes   = 0;
	int stall_left    = 0;
	bit steady        = 1'b0;

	always #1 clk = ~clk;

	sprite_clip_frame_sequencer_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.clip_sel     (clip_sel),
		.delta_ms     (delta_ms),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.active_clip  (active_clip),
		.frame_number (frame_number),
		.frame_valid  (frame_valid),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	sprite_clip_frame_checker frame_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.cmd             (cmd),
		.clip_sel        (clip_sel),
		.delta_ms        (delta_ms),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.active_clip     (active_clip),
		.frame_number    (frame_number),
		.frame_valid     (frame_valid),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.pending         (pending),
		.reports_checked (reports_checked)
	);

	// Idle lengths for both channels: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic desc_t pack_desc(input bit present, input bit has_follow,
			input logic [CLIP_BITS-1:0] follow, input bit loops,
			input logic [PERIOD_BITS-1:0] period, input logic [FRAME_BITS-1:0] frames);
		desc_t d;
		d = '0;
		d[PRESENT_BIT]                 = present;
		d[HASNEXT_BIT]                 = has_follow;
		d[NEXT_LSB +: CLIP_BITS]       = follow;
		d[LOOP_BIT]                    = loops;
		d[PERIOD_LSB +: PERIOD_BITS]   = period;
		d[FRAMES_LSB +: FRAME_BITS]    = frames;
		return d;
	endfunction

	// Periods are mostly a few to a few tens of milliseconds so that the short ticks below
	// advance a handful of frames; zero and full-scale values show up now and then.
	function automatic desc_t random_desc();
		logic [FRAME_BITS-1:0]  frames;
		logic [PERIOD_BITS-1:0] period;
		int                     r;
		r = $urandom_range(0, 15);
		if (r == 0)
			frames = '0;
		else if (r < 3)
			frames = 8'd1;
		else if (r < 12)
			frames = 8'($urandom_range(2, 8));
		else if (r < 15)
			frames = 8'($urandom_range(9, 255));
		else
			frames = '1;
		r = $urandom_range(0, 15);
		if (r == 0)
			period = '0;
		else if (r < 4)
			period = 24'($urandom_range(1, 999));
		else if (r < 12)
			period = 24'($urandom_range(1, 60) * 1000 + $urandom_range(0, 999));
		else if (r < 15)
			period = 24'($urandom_range(1, 24'hFFFFFF));
		else
			period = '1;
		return pack_desc($urandom_range(0, 7) != 0, $urandom_range(0, 3) != 0,
			CLIP_BITS'($urandom_range(0, 3)), 1'($urandom), period, frames);
	endfunction

	function automatic logic [DELTA_BITS-1:0] random_delta();
		int r;
		r = $urandom_range(0, 15);
		if (r == 0)
			return '0;
		if (r < 10)
			return DELTA_BITS'($urandom_range(1, 40));
		if (r < 13)
			return DELTA_BITS'($urandom_range(41, 400));
		if (r < 15)
			return DELTA_BITS'($urandom_range(0, 65535));
		return '1;
	endfunction

	// The write enable rises at one falling edge and drops at the next, so a string of
	// writes never assigns it twice in the same time step.
	task automatic write_clip_desc(input logic [CLIP_BITS-1:0] idx, input desc_t value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		desc_writes++;
	endtask

	// One transaction on the input channel. Valid only drops when a gap is wanted, and it
	// then rises again at a later falling edge; it never waits for ready to go high.
	task automatic push_item(input logic c, input logic [CLIP_BITS-1:0] sel,
			input logic [DELTA_BITS-1:0] delta);
		int gap;
		gap = steady ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= c;
		clip_sel <= sel;
		delta_ms <= delta;
		if (c == CMD_REQUEST)
			requests_sent++;
		else
			ticks_sent++;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Quiet the input channel and wait until every expected result has come back, so the
	// descriptors can be rewritten while the sequencer is idle.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly ticks with a request now and then. The saturating flavor feeds full-scale
	// ticks so that the elapsed time runs into its ceiling.
	task automatic random_phase(input int count, input bit saturate);
		logic [DELTA_BITS-1:0] delta;
		bit                    is_request;
		for (int i = 0; i < count; i++) begin
			if (saturate) begin
				is_request = ($urandom_range(0, 9) == 0);
				delta      = ($urandom_range(0, 7) == 0) ? random_delta() : '1;
			end else begin
				is_request = ($urandom_range(0, 3) == 0);
				delta      = random_delta();
			end
			push_item(is_request ? CMD_REQUEST : CMD_TICK, CLIP_BITS'($urandom_range(0, 3)),
				delta);
		end
	endtask

	// The result channel stalls on its own schedule, except in steady phases.
	always @(negedge clk) begin
		if (steady) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			out_ready <= 1'b1;
			stall_left = pick_gap();
		end
	end

	// Watchdog: a correct run finishes far below this count.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
				pending);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Straight out of reset every descriptor is empty: ticks only pile up time and a
		// request for an absent clip is ignored.
		push_item(CMD_TICK, CLIP0, '0);
		push_item(CMD_TICK, CLIP0, '1);
		push_item(CMD_REQUEST, CLIP1, '0);
		settle();

		// Clip 0 loops over four 1 ms frames, clip 1 is a one-shot that hands over to clip 2,
		// clip 2 is the longest one-shot and names itself as follower, and clip 3 has a zero
		// period so it never advances.
		write_clip_desc(CLIP0, pack_desc(1'b1, 1'b0, CLIP0, 1'b1, 24'd1000, 8'd4));
		write_clip_desc(CLIP1, pack_desc(1'b1, 1'b1, CLIP2, 1'b0, 24'd2000, 8'd3));
		write_clip_desc(CLIP2, pack_desc(1'b1, 1'b1, CLIP2, 1'b0, '1, '1));
		write_clip_desc(CLIP3, pack_desc(1'b1, 1'b0, CLIP0, 1'b1, '0, 8'd5));
		push_item(CMD_REQUEST, CLIP0, '0);	// same clip, ignored
		push_item(CMD_TICK, CLIP0, '0);		// burns the time piled up before
		push_item(CMD_TICK, CLIP0, 16'd1);
		push_item(CMD_TICK, CLIP0, 16'd3);	// advances three frames to frame 3
		push_item(CMD_REQUEST, CLIP1, '0);
		push_item(CMD_TICK, CLIP1, 16'd1);	// half a period, no advance
		push_item(CMD_TICK, CLIP1, 16'd1);
		push_item(CMD_TICK, CLIP1, '1);		// runs off the end into clip 2
		push_item(CMD_REQUEST, CLIP2, '0);	// already playing, ignored
		push_item(CMD_TICK, CLIP2, '1);
		push_item(CMD_TICK, CLIP2, '1);
		push_item(CMD_REQUEST, CLIP3, '0);
		push_item(CMD_TICK, CLIP3, '1);		// zero period, time only accumulates
		push_item(CMD_REQUEST, CLIP0, '0);
		push_item(CMD_TICK, CLIP0, 16'd3);	// lands on frame 3
		settle();

		// Shrinking clip 0 leaves the frame index past the end of the clip.
		write_clip_desc(CLIP0, pack_desc(1'b1, 1'b0, CLIP0, 1'b1, 24'd1000, 8'd2));
		push_item(CMD_TICK, CLIP0, '0);
		push_item(CMD_TICK, CLIP0, 16'd1);
		settle();

		// A one-shot whose follower is absent holds its last frame.
		write_clip_desc(CLIP1, '0);
		write_clip_desc(CLIP0, pack_desc(1'b1, 1'b1, CLIP1, 1'b0, 24'd1000, 8'd2));
		push_item(CMD_TICK, CLIP0, 16'd5);
		push_item(CMD_TICK, CLIP0, 16'd1);

		// Random phases, each with its own descriptor set. One phase clears every
		// descriptor and saturates the elapsed time, the next one consumes it; another
		// sets every descriptor bit. Every third phase runs without idling.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			settle();
			steady = (p % 3 == 1);
			for (int i = 0; i < NUM_DESC; i++) begin
				if (p == 2)
					write_clip_desc(CLIP_BITS'(i), '0);
				else if (p == 5)
					write_clip_desc(CLIP_BITS'(i), '1);
				else
					write_clip_desc(CLIP_BITS'(i), random_desc());
			end
			random_phase((p == 2) ? 150 : 95, p == 2);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		steady = 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d transactions (%0d clip requests, %0d ticks) and checked %0d results.",
			requests_sent + ticks_sent, requests_sent, ticks_sent, reports_checked);
		$display("Made %0d descriptor writes over %0d settings, empty and fully set among them.",
			desc_writes, RANDOM_PHASES + 4);
		if (fail_count == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
